/* src/tadc_seq_pkg.sv */
// Shared types and constants of the touch ADC sample sequencer.
`default_nettype none
package tadc_seq_pkg;

  localparam int unsigned AdcBits = 12;

  // Configuration register indexes
  localparam logic [1:0] RegSamplePeriod = 2'd0;
  localparam logic [1:0] RegRetryLimit   = 2'd1;
  localparam logic [1:0] RegContactWait  = 2'd2;

  localparam logic [7:0] SamplePeriodRst = 8'd2;
  localparam logic [1:0] RetryLimitRst   = 2'd3;
  localparam logic [7:0] ContactWaitRst  = 8'd2;

  // Sequencer phases
  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhXWarm = 3'd1;
  localparam logic [2:0] PhXAvg  = 3'd2;
  localparam logic [2:0] PhYWarm = 3'd3;
  localparam logic [2:0] PhYAvg  = 3'd4;
  localparam logic [2:0] PhWait  = 3'd5;

  // Converter command bytes: start bit, channel, mode, powerdown
  localparam logic [7:0] CmdStart = 8'(1 << 7);
  localparam logic [7:0] CmdX     = CmdStart | 8'(5 << 4) | 8'd2;
  localparam logic [7:0] CmdY     = CmdStart | 8'(1 << 4) | 8'd2;
  localparam logic [7:0] CmdOff   = CmdStart | 8'(1 << 2);

  typedef struct packed {
    logic [7:0] sample_period_ticks;
    logic [1:0] retry_limit;
    logic [7:0] contact_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic               pen_released;
    logic [AdcBits-1:0] sample;
  } item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [7:0]         cmd_byte;
    logic               x_valid;
    logic [AdcBits-1:0] x_pos;
    logic               y_valid;
    logic [AdcBits-1:0] y_pos;
    logic               pen_up;
    logic [7:0]         wait_ticks;
    logic               pen_irq_armed;
  } result_t;

endpackage
`default_nettype wire

/* src/tadc_seq_cfg.sv */
// Configuration registers of the touch ADC sample sequencer.
`default_nettype none
module tadc_seq_cfg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_wdata_i,
  output tadc_seq_pkg::cfg_t      cfg_o
);
  import tadc_seq_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period_ticks <= SamplePeriodRst;
      cfg_q.retry_limit         <= RetryLimitRst;
      cfg_q.contact_wait_ticks  <= ContactWaitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSamplePeriod: cfg_q.sample_period_ticks <= cfg_wdata_i;
        RegRetryLimit:   cfg_q.retry_limit         <= cfg_wdata_i[1:0];
        RegContactWait:  cfg_q.contact_wait_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* src/tadc_seq_step.sv */
// Sequencer state and the combinational step logic for one wakeup word.
`default_nettype none
module tadc_seq_step (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire tadc_seq_pkg::item_t  item_i,
  input  wire tadc_seq_pkg::cfg_t   cfg_i,
  output tadc_seq_pkg::result_t     res_o
);
  import tadc_seq_pkg::*;

  logic [2:0]         phase_q, phase_d;
  logic [1:0]         count_q, count_d;
  logic [1:0]         retries_q, retries_d;
  logic [AdcBits-1:0] avg_q, avg_d;
  logic               touching_q, touching_d;
  logic [7:0]         wait_q, wait_d;

  logic               data;
  logic [1:0]         count_inc;
  logic [1:0]         retry_inc;
  logic [AdcBits:0]   avg_sum;
  logic [AdcBits-1:0] avg_half;
  result_t            res;

  assign data      = !item_i.func;
  assign count_inc = count_q + 2'd1;
  assign retry_inc = retries_q + 2'd1;
  assign avg_sum   = {1'b0, avg_q} + {1'b0, item_i.sample};
  assign avg_half  = avg_sum[AdcBits:1];

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    retries_d  = retries_q;
    avg_d      = avg_q;
    touching_d = touching_q;
    wait_d     = wait_q;
    res        = '0;

    case (phase_q)
      PhXWarm: begin
        if (data) begin
          avg_d     = item_i.sample;
          count_d   = count_inc;
          retries_d = '0;
          if (count_inc == 2'd3) begin
            phase_d = PhXAvg;
            count_d = '0;
          end
        end else if (item_i.pen_released) begin
          wait_d     = '0;
          phase_d    = PhIdle;
          retries_d  = '0;
          touching_d = 1'b0;
          res.pen_up = 1'b1;
          res.pen_irq_armed = 1'b1;
        end else begin
          retries_d = retry_inc;
        end
        if (phase_d != PhIdle) begin
          res.cmd_valid = 1'b1;
          if (retries_d < cfg_i.retry_limit) begin
            res.cmd_byte = CmdX;
          end else begin
            res.cmd_byte = CmdOff;
            retries_d    = '0;
            wait_d       = '0;
            phase_d      = PhIdle;
          end
        end
      end
      PhXAvg, PhYAvg: begin
        res.cmd_valid = 1'b1;
        if (data) begin
          avg_d   = avg_half;
          count_d = count_inc;
          // Y averaging keeps the retry count on data
          if (phase_q == PhXAvg) retries_d = '0;
          if (count_inc == 2'd3) begin
            count_d = '0;
            if (phase_q == PhXAvg) begin
              res.cmd_byte = CmdY;
              res.x_valid  = 1'b1;
              res.x_pos    = avg_half;
              phase_d      = PhYWarm;
            end else begin
              res.cmd_byte = CmdOff;
              res.y_valid  = 1'b1;
              res.y_pos    = avg_half;
              phase_d      = PhWait;
            end
          end else begin
            res.cmd_byte = (phase_q == PhXAvg) ? CmdX : CmdY;
          end
        end else begin
          retries_d = retry_inc;
          if (retry_inc < cfg_i.retry_limit) begin
            res.cmd_byte = (phase_q == PhXAvg) ? CmdX : CmdY;
          end else begin
            res.cmd_byte = CmdOff;
            retries_d    = '0;
            wait_d       = '0;
            phase_d      = PhIdle;
          end
        end
      end
      PhYWarm: begin
        res.cmd_valid = 1'b1;
        if (data) begin
          avg_d     = item_i.sample;
          count_d   = count_inc;
          retries_d = '0;
          if (count_inc == 2'd3) begin
            phase_d = PhYAvg;
            count_d = '0;
          end
        end else begin
          retries_d = retry_inc;
        end
        if (retries_d < cfg_i.retry_limit) begin
          res.cmd_byte = CmdY;
        end else begin
          res.cmd_byte = CmdOff;
          retries_d    = '0;
          wait_d       = '0;
          phase_d      = PhIdle;
        end
      end
      PhWait: begin
        wait_d  = cfg_i.sample_period_ticks;
        phase_d = PhXWarm;
        count_d = '0;
      end
      default: begin
        // idle and the unused phase codes
        phase_d = PhIdle;
        if (!item_i.pen_released) begin
          touching_d    = 1'b1;
          wait_d        = cfg_i.contact_wait_ticks;
          phase_d       = PhXWarm;
          count_d       = '0;
          retries_d     = '0;
          res.cmd_valid = 1'b1;
          res.cmd_byte  = CmdX;
        end else begin
          if (data) begin
            wait_d    = '0;
            count_d   = '0;
            retries_d = '0;
            res.pen_irq_armed = 1'b1;
          end
          if (touching_q) begin
            touching_d = 1'b0;
            res.pen_up = 1'b1;
          end
        end
      end
    endcase

    res.wait_ticks = wait_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      count_q    <= '0;
      retries_q  <= '0;
      avg_q      <= '0;
      touching_q <= 1'b0;
      wait_q     <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      retries_q  <= retries_d;
      avg_q      <= avg_d;
      touching_q <= touching_d;
      wait_q     <= wait_d;
    end
  end

  assign res_o = res;

endmodule
`default_nettype wire

/* src/touch_adc_sample_sequencer_unit.sv */
// Touch ADC sample sequencer: input register, step logic, result register.
//
// One wakeup word goes in per cycle while in_stall_o is low, and one result
// word comes out for each. A word waits in the input register, where the step
// logic works on it against the sequencer state, and leaves through the
// result register, which is loaded when the step logic fires. The
// result register holds a word until it is taken while the next word waits in
// the input register. Configuration writes take effect on the next cycle and
// are meant for times when no word is in flight.
`default_nettype none
module touch_adc_sample_sequencer_unit #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        func_i,
  input  wire logic        pen_released_i,
  input  wire logic [11:0] adc_sample_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        cmd_valid_o,
  output      logic [7:0]  cmd_byte_o,
  output      logic        x_valid_o,
  output      logic [11:0] x_pos_o,
  output      logic        y_valid_o,
  output      logic [11:0] y_pos_o,
  output      logic        pen_up_o,
  output      logic [7:0]  wait_ticks_o,
  output      logic        pen_irq_armed_o
);
  import tadc_seq_pkg::*;

  localparam logic [AdcBits-1:0] SampleMask = (SAMPLE_BITS >= AdcBits) ?
      {AdcBits{1'b1}} : AdcBits'((1 << SAMPLE_BITS) - 1);

  cfg_t    cfg;
  logic    in_valid_q;
  item_t   in_item_q;
  item_t   step_item;
  logic    out_valid_q;
  result_t out_res_q;
  result_t step_res;
  logic    out_take;
  logic    fire;

  assign out_take   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_take;
  assign in_stall_o = in_valid_q && !out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q.func         <= func_i;
      in_item_q.pen_released <= pen_released_i;
      in_item_q.sample       <= adc_sample_i;
    end
  end

  always_comb begin
    step_item        = in_item_q;
    step_item.sample = in_item_q.sample & SampleMask;
  end

  tadc_seq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tadc_seq_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (step_item),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= in_valid_q;
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_valid_o     = out_res_q.cmd_valid;
  assign cmd_byte_o      = out_res_q.cmd_byte;
  assign x_valid_o       = out_res_q.x_valid;
  assign x_pos_o         = out_res_q.x_pos;
  assign y_valid_o       = out_res_q.y_valid;
  assign y_pos_o         = out_res_q.y_pos;
  assign pen_up_o        = out_res_q.pen_up;
  assign wait_ticks_o    = out_res_q.wait_ticks;
  assign pen_irq_armed_o = out_res_q.pen_irq_armed;

endmodule
`default_nettype wire
